FILE: hw/rtl/indexed_min_heap_priority_queue_assert.svh
// assertion macros
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IMH_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define IMH_ASSERT(lbl, clk, rstn, prop, msg)
`define IMH_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

FILE: hw/rtl/imh_pkg.sv
`default_nettype none
package imh_pkg;
  localparam int unsigned HeapDepth   = 256;
  localparam int unsigned VertexCount = 256;
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned SlotW       = $clog2(HeapDepth + 1);
  localparam int unsigned AddrW       = $clog2(HeapDepth);
  localparam int unsigned VtxW        = $clog2(VertexCount);

  typedef enum logic [1:0] {
    FuncInsert   = 2'd0,
    FuncExtract  = 2'd1,
    FuncDecrease = 2'd2,
    FuncNop      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StEmpty    = 2'd2,
    StRejected = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  vertex;
    logic [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_vertex;
    logic [31:0] out_key;
    logic [8:0]  size_now;
    logic [3:0]  heapify_steps;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_DISPATCH,
    S_INS_W,
    S_DEC_PM, S_DEC_RD, S_DEC_CHK,
    S_EX_RD1, S_EX_RDL, S_EX_W1, S_EX_PM,
    S_UP_RD, S_UP_CMP, S_UP_SWAPA, S_UP_SWAPB,
    S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_SWAPA, S_DN_SWAPB,
    S_EX_CLRPM, S_DONE
  } state_e;

  // memory request from sequencer
  typedef struct packed {
    logic             slot_we;
    logic [AddrW-1:0] slot_waddr;
    logic [VtxW-1:0]  slot_wvtx;
    logic [KeyBits-1:0] slot_wkey;
    logic             slot_re;
    logic [AddrW-1:0] slot_raddr;
    logic             pm_we;
    logic [VtxW-1:0]  pm_waddr;
    logic [SlotW-1:0] pm_wdata;
    logic             pm_re;
    logic [VtxW-1:0]  pm_raddr;
  } mem_req_t;

  function automatic logic [AddrW-1:0] slot_addr(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] t;
    t = s - SlotW'(1);
    return t[AddrW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/indexed_min_heap_priority_queue.sv
`default_nettype none
// Busy from the start edge until the result strobe; the next start may be taken at the
// edge that ends the strobe, so a new word is taken only after the last one is done.
// Full, empty or unknown words go straight to the result; insert writes and sifts up;
// decrease checks, then sifts up unless rejected; extract moves the last entry to the
// root and sifts down. After reset a pass clears the position map while busy is high.
// The receiver cannot stall: result_valid_o is high for exactly one cycle.
module indexed_min_heap_priority_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  output logic                   busy,
  input  imh_pkg::in_word_t      in_word_i,
  output logic                   result_valid_o,
  output imh_pkg::out_word_t     result_o,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire [8:0]              cfg_data_i
);
  import imh_pkg::*;

  state_e state_q, state_d;
  logic [8:0]         cap_q;
  logic [SlotW-1:0]   size_q, size_d;
  logic [VtxW-1:0]    clr_q, clr_d;
  logic [1:0]         func_q, func_d;
  logic [VtxW-1:0]    vtx_q, vtx_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [SlotW-1:0]   at_q, at_d, oth_q, oth_d;
  // entry at 'at' and at 'oth'
  logic [VtxW-1:0]    av_q, av_d, bv_q, bv_d;
  logic [KeyBits-1:0] ak_q, ak_d, bk_q, bk_d;
  logic [VtxW-1:0]    topv_q, topv_d;
  logic [KeyBits-1:0] topk_q, topk_d;
  logic [3:0]         steps_q, steps_d;
  logic [1:0]         st_q, st_d;
  logic               rv_q, rv_d;
  out_word_t          res_q, res_d;
  mem_req_t           req;
  logic [VtxW-1:0]    rd_vtx;
  logic [KeyBits-1:0] rd_key;
  logic [SlotW-1:0]   pm_rdata;
  logic [SlotW-1:0]   limit, lch;
  logic               rch_win;

  imh_mem u_mem (
    .clk_i, .rst_ni, .req_i(req),
    .rd_vtx_o(rd_vtx), .rd_key_o(rd_key), .pm_rdata_o(pm_rdata)
  );

  assign limit = (cap_q < SlotW'(HeapDepth)) ? cap_q : SlotW'(HeapDepth);
  assign lch = {at_q[SlotW-2:0], 1'b0};
  assign rch_win = ((lch | SlotW'(1)) <= size_q) && (at_q[SlotW-1] == 1'b0) &&
                   (rd_key < ((oth_q == at_q) ? ak_q : bk_q));
  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = rv_q;
  assign result_o = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (clr_q == VtxW'(VertexCount - 1)) state_d = S_IDLE;
      S_IDLE:     if (start) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (func_e'(func_q))
          FuncInsert:   state_d = (size_q >= limit) ? S_DONE : S_INS_W;
          FuncExtract:  state_d = (size_q == '0) ? S_DONE : S_EX_RD1;
          FuncDecrease: state_d = S_DEC_PM;
          default:      state_d = S_DONE;
        endcase
      end
      S_INS_W:    state_d = S_UP_RD;
      S_DEC_PM:   state_d = S_DEC_RD;
      S_DEC_RD:   state_d = S_DEC_CHK;
      S_DEC_CHK:  state_d = ((at_q == '0) || (at_q > size_q) || (rd_vtx != vtx_q)
                             || (key_q > rd_key)) ? S_DONE : S_UP_RD;
      S_UP_RD:    state_d = (at_q <= SlotW'(1)) ? S_DONE : S_UP_CMP;
      S_UP_CMP:   state_d = (ak_q < rd_key) ? S_UP_SWAPA : S_DONE;
      S_UP_SWAPA: state_d = S_UP_SWAPB;
      S_UP_SWAPB: state_d = S_UP_RD;
      S_EX_RD1:   state_d = S_EX_RDL;
      S_EX_RDL:   state_d = S_EX_W1;
      S_EX_W1:    state_d = S_EX_PM;
      S_EX_PM:    state_d = S_DN_RDL;
      S_DN_RDL:   state_d = S_DN_RDR;
      S_DN_RDR:   state_d = S_DN_CMP;
      S_DN_CMP:   state_d = ((oth_q == at_q) && !rch_win) ? S_EX_CLRPM : S_DN_SWAPA;
      S_DN_SWAPA: state_d = S_DN_SWAPB;
      S_DN_SWAPB: state_d = S_DN_RDL;
      S_EX_CLRPM: state_d = S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    size_d = size_q; clr_d = clr_q; func_d = func_q; vtx_d = vtx_q; key_d = key_q;
    at_d = at_q; oth_d = oth_q; av_d = av_q; bv_d = bv_q; ak_d = ak_q; bk_d = bk_q;
    topv_d = topv_q; topk_d = topk_q; steps_d = steps_q; st_d = st_q;
    rv_d = 1'b0; res_d = res_q;
    unique case (state_q)
      S_CLEAR: begin
        req.pm_we = 1'b1; req.pm_waddr = clr_q; req.pm_wdata = '0;
        clr_d = clr_q + VtxW'(1);
      end
      S_IDLE: if (start) begin
        func_d = in_word_i.func; vtx_d = in_word_i.vertex; key_d = in_word_i.key;
        st_d = StOk; steps_d = '0; topv_d = '0; topk_d = '0;
      end
      S_DISPATCH: begin
        unique case (func_e'(func_q))
          FuncInsert: begin
            if (size_q >= limit) st_d = StFull;
            else begin
              size_d = size_q + SlotW'(1); at_d = size_q + SlotW'(1);
              av_d = vtx_q; ak_d = key_q;
            end
          end
          FuncExtract: if (size_q == '0) st_d = StEmpty;
          FuncDecrease: begin
            req.pm_re = 1'b1; req.pm_raddr = vtx_q;
          end
          default: ;
        endcase
      end
      S_INS_W: begin
        req.slot_we = 1'b1; req.slot_waddr = slot_addr(at_q);
        req.slot_wvtx = av_q; req.slot_wkey = ak_q;
        req.pm_we = 1'b1; req.pm_waddr = av_q; req.pm_wdata = at_q;
      end
      S_DEC_PM: begin
        at_d = pm_rdata;
        req.slot_re = 1'b1; req.slot_raddr = slot_addr(pm_rdata);
      end
      S_DEC_RD: ;
      S_DEC_CHK: begin
        if ((at_q == '0) || (at_q > size_q) || (rd_vtx != vtx_q) || (key_q > rd_key)) begin
          st_d = StRejected;
        end else begin
          av_d = vtx_q; ak_d = key_q;
          req.slot_we = 1'b1; req.slot_waddr = slot_addr(at_q);
          req.slot_wvtx = vtx_q; req.slot_wkey = key_q;
        end
      end
      S_UP_RD: begin
        oth_d = {1'b0, at_q[SlotW-1:1]};
        req.slot_re = 1'b1; req.slot_raddr = slot_addr({1'b0, at_q[SlotW-1:1]});
      end
      S_UP_CMP: begin
        bv_d = rd_vtx; bk_d = rd_key;
      end
      // parent's position goes first so the moving entry's position lands last
      S_UP_SWAPA: begin
        req.slot_we = 1'b1; req.slot_waddr = slot_addr(oth_q);
        req.slot_wvtx = av_q; req.slot_wkey = ak_q;
        req.pm_we = 1'b1; req.pm_waddr = bv_q; req.pm_wdata = at_q;
      end
      S_UP_SWAPB: begin
        req.slot_we = 1'b1; req.slot_waddr = slot_addr(at_q);
        req.slot_wvtx = bv_q; req.slot_wkey = bk_q;
        req.pm_we = 1'b1; req.pm_waddr = av_q; req.pm_wdata = oth_q;
        at_d = oth_q;
      end
      S_EX_RD1: begin
        req.slot_re = 1'b1; req.slot_raddr = slot_addr(SlotW'(1));
      end
      S_EX_RDL: begin
        topv_d = rd_vtx; topk_d = rd_key;
        req.slot_re = 1'b1; req.slot_raddr = slot_addr(size_q);
      end
      S_EX_W1: begin
        av_d = rd_vtx; ak_d = rd_key;
        req.slot_we = 1'b1; req.slot_waddr = slot_addr(SlotW'(1));
        req.slot_wvtx = rd_vtx; req.slot_wkey = rd_key;
        size_d = size_q - SlotW'(1); at_d = SlotW'(1);
      end
      S_EX_PM: begin
        req.pm_we = 1'b1; req.pm_waddr = av_q; req.pm_wdata = SlotW'(1);
      end
      S_DN_RDL: begin
        steps_d = steps_q + 4'd1; oth_d = at_q;
        req.slot_re = 1'b1; req.slot_raddr = slot_addr(lch);
      end
      S_DN_RDR: begin
        if ((lch <= size_q) && (at_q[SlotW-1] == 1'b0) && (rd_key < ak_q)) begin
          oth_d = lch; bv_d = rd_vtx; bk_d = rd_key;
        end
        req.slot_re = 1'b1; req.slot_raddr = slot_addr(lch | SlotW'(1));
      end
      S_DN_CMP: begin
        if (rch_win) begin
          oth_d = lch | SlotW'(1); bv_d = rd_vtx; bk_d = rd_key;
        end
      end
      S_DN_SWAPA: begin
        req.slot_we = 1'b1; req.slot_waddr = slot_addr(at_q);
        req.slot_wvtx = bv_q; req.slot_wkey = bk_q;
        req.pm_we = 1'b1; req.pm_waddr = bv_q; req.pm_wdata = at_q;
      end
      S_DN_SWAPB: begin
        req.slot_we = 1'b1; req.slot_waddr = slot_addr(oth_q);
        req.slot_wvtx = av_q; req.slot_wkey = ak_q;
        req.pm_we = 1'b1; req.pm_waddr = av_q; req.pm_wdata = oth_q;
        at_d = oth_q;
      end
      S_EX_CLRPM: begin
        req.pm_we = 1'b1; req.pm_waddr = topv_q; req.pm_wdata = '0;
      end
      S_DONE: begin
        rv_d = 1'b1;
        res_d.status = st_q; res_d.out_vertex = topv_q; res_d.out_key = topk_q;
        res_d.size_now = size_q; res_d.heapify_steps = steps_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cap_q <= 9'd256; size_q <= '0; clr_q <= '0; rv_q <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d; size_q <= size_d; clr_q <= clr_d; rv_q <= rv_d;
      steps_q <= steps_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; vtx_q <= vtx_d; key_q <= key_d; at_q <= at_d; oth_q <= oth_d;
    av_q <= av_d; bv_q <= bv_d; ak_q <= ak_d; bk_q <= bk_d;
    topv_q <= topv_d; topk_q <= topk_d; st_q <= st_d; res_q <= res_d;
  end

  `include "indexed_min_heap_priority_queue_assert.svh"
  `IMH_ASSERT(a_size_cap, clk_i, rst_ni, size_q <= SlotW'(HeapDepth), "size overflow")
  `IMH_ASSERT_NEXT(a_one_strobe, clk_i, rst_ni, rv_q, !rv_q, "strobe longer than one cycle")
  `IMH_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start && !busy, busy, "start not taken")
  `IMH_ASSERT(a_steps_range, clk_i, rst_ni, steps_q <= 4'd9, "too many sift-down levels")
endmodule
`default_nettype wire

FILE: hw/rtl/imh_mem.sv
`default_nettype none
module imh_mem (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  imh_pkg::mem_req_t       req_i,
  output logic [imh_pkg::VtxW-1:0]    rd_vtx_o,
  output logic [imh_pkg::KeyBits-1:0] rd_key_o,
  output logic [imh_pkg::SlotW-1:0]   pm_rdata_o
);
  import imh_pkg::*;

  logic [VtxW-1:0]    vtx_mem [HeapDepth];
  logic [KeyBits-1:0] key_mem [HeapDepth];
  logic [SlotW-1:0]   pm_mem  [VertexCount];

  always_ff @(posedge clk_i) begin
    if (req_i.slot_we) begin
      vtx_mem[req_i.slot_waddr] <= req_i.slot_wvtx;
      key_mem[req_i.slot_waddr] <= req_i.slot_wkey;
    end
    if (req_i.slot_re) begin
      rd_vtx_o <= vtx_mem[req_i.slot_raddr];
      rd_key_o <= key_mem[req_i.slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pm_we) begin
      pm_mem[req_i.pm_waddr] <= req_i.pm_wdata;
    end
    if (req_i.pm_re) begin
      pm_rdata_o <= pm_mem[req_i.pm_raddr];
    end
  end

  `include "indexed_min_heap_priority_queue_assert.svh"
  `IMH_ASSERT(a_pm_range, clk_i, rst_ni, !req_i.pm_we || (req_i.pm_wdata <= SlotW'(HeapDepth)), "pm write out of range")
  `IMH_ASSERT(a_no_rw_slot, clk_i, rst_ni, !(req_i.slot_we && req_i.slot_re && (req_i.slot_waddr == req_i.slot_raddr)), "slot read during write")
  `IMH_ASSERT(a_no_rw_pm, clk_i, rst_ni, !(req_i.pm_we && req_i.pm_re && (req_i.pm_waddr == req_i.pm_raddr)), "pm read during write")
endmodule
`default_nettype wire
